>>> hdl/powerpc_integer_subset_core_unit_macros.svh
// ----------------------------------------------------------------------------
// PowerPC integer subset core - assertion macros
// Shared concurrent assertion forms, clocked on rising edge, reset low aborts.
// ----------------------------------------------------------------------------
`ifndef POWERPC_INTEGER_SUBSET_CORE_UNIT_MACROS_SVH
`define POWERPC_INTEGER_SUBSET_CORE_UNIT_MACROS_SVH

// lbl: name, clk/rst_n: clock and active-low reset, prop: property body
`define PPCISC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal holds its value in the cycle after cond
`define PPCISC_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

>>> hdl/ppcisc_pkg.sv
// ----------------------------------------------------------------------------
// ppcisc_pkg
// Types, opcodes and helper functions for the PowerPC integer subset core.
// ----------------------------------------------------------------------------
package ppcisc_pkg;

    localparam logic       SEL_INSN = 1'b0;
    localparam logic       SEL_LOAD = 1'b1;

    localparam logic [5:0] OP_ADDI   = 6'd14;
    localparam logic [5:0] OP_ADDIS  = 6'd15;
    localparam logic [5:0] OP_BRANCH = 6'd18;
    localparam logic [5:0] OP_RLWINM = 6'd21;
    localparam logic [5:0] OP_ORI    = 6'd24;
    localparam logic [5:0] OP_ORIS   = 6'd25;
    localparam logic [5:0] OP_EXT31  = 6'd31;
    localparam logic [5:0] OP_LWZ    = 6'd32;
    localparam logic [5:0] OP_STW    = 6'd36;

    localparam logic [9:0] XO_ADD  = 10'd266;
    localparam logic [9:0] XO_SUBF = 10'd40;

    localparam logic [3:0] CR_NEG  = 4'h8;
    localparam logic [3:0] CR_POS  = 4'h4;
    localparam logic [3:0] CR_ZERO = 4'h2;

    localparam logic       REG_RESET_PC = 1'b0;

    typedef struct packed {
        logic        opcode;
        logic [31:0] instruction_word;
        logic [31:0] load_data;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic [3:0]  cr0_bits;
        logic        fault;
    } t_out_beat;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] sh);
        return (v << sh) | (v >> (6'd32 - {1'b0, sh}));
    endfunction

    function automatic logic [31:0] wrap_mask(input logic [4:0] mb, input logic [4:0] me);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = 32'hFFFF_FFFF >> mb;
        lo = 32'hFFFF_FFFF << (5'd31 - me);
        return (mb <= me) ? (hi & lo) : (hi | lo);
    endfunction

    function automatic logic [3:0] cr0_of(input logic [31:0] v);
        logic [3:0] c;
        if (v == 32'd0) begin
            c = CR_ZERO;
        end else if (v[31]) begin
            c = CR_NEG;
        end else begin
            c = CR_POS;
        end
        return c;
    endfunction

endpackage

>>> hdl/powerpc_integer_subset_core_unit.sv
// ----------------------------------------------------------------------------
// powerpc_integer_subset_core_unit
// PowerPC integer subset core: one instruction or load-return beat per step.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  in      | in  | i_in_valid / o_in_stall    | i_in  (ppcisc_pkg::t_in_beat)
//  out     | out | o_out_valid / i_out_stall  | o_out (ppcisc_pkg::t_out_beat)
//  cfg     | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One beat per cycle unless the output stalls; a beat goes via r_ex, then r_out.
// The register file is read (with write-through) at accept, executed from the
// input register, written back as the result register loads.
// Reset clears control state and the register file valid bits (no sweep).
// A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
module powerpc_integer_subset_core_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ppcisc_pkg::t_in_beat  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ppcisc_pkg::t_out_beat o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                  r_ex_vld;
    ppcisc_pkg::t_in_beat  r_ex;
    logic                  r_out_vld;
    ppcisc_pkg::t_out_beat r_out;

    logic [31:0] r_reset_pc;
    logic [31:0] r_pc;
    logic [31:0] r_lr;
    logic [3:0]  r_cr;
    logic        r_halt;
    logic        r_wait;
    logic [4:0]  r_ldst;

    logic [31:0] r_rf_mem [32];
    logic [31:0] r_rf_vld;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;

    logic in_acc;
    logic adv;
    logic cfg_wr;

    logic [4:0]  addr_a;
    logic [4:0]  addr_b;

    logic [31:0] n_pc;
    logic [31:0] n_lr;
    logic [3:0]  n_cr;
    logic        n_halt;
    logic        n_wait;
    logic [4:0]  n_ldst;
    ppcisc_pkg::t_out_beat n_out;

    logic        ex_we;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;

    logic [31:0] w;
    logic [5:0]  primary;
    logic [4:0]  f_rd;
    logic [4:0]  f_ra;
    logic [4:0]  f_rb;
    logic [31:0] base;
    logic [31:0] simm;
    logic [31:0] ea;
    logic [31:0] br_off;
    logic [31:0] alu;

    assign adv        = r_ex_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_ex_vld && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == ppcisc_pkg::REG_RESET_PC) ? r_reset_pc : 32'd0;

    // register file read ports: ra, and rb for X-form else rs/rt
    assign addr_a = i_in.instruction_word[20:16];
    assign addr_b = (i_in.instruction_word[31:26] == ppcisc_pkg::OP_EXT31)
                  ? i_in.instruction_word[15:11] : i_in.instruction_word[25:21];

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf_mem[rf_waddr] <= rf_wdata;
        end
        if (in_acc) begin
            r_rd_a <= (rf_we && rf_waddr == addr_a) ? rf_wdata
                    : (r_rf_vld[addr_a] ? r_rf_mem[addr_a] : 32'd0);
            r_rd_b <= (rf_we && rf_waddr == addr_b) ? rf_wdata
                    : (r_rf_vld[addr_b] ? r_rf_mem[addr_b] : 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[rf_waddr] <= 1'b1;
        end
    end

    // execute
    assign w       = r_ex.instruction_word;
    assign primary = w[31:26];
    assign f_rd    = w[25:21];
    assign f_ra    = w[20:16];
    assign f_rb    = w[15:11];
    assign base    = (f_ra == 5'd0) ? 32'd0 : r_rd_a;
    assign simm    = ppcisc_pkg::sext16(w[15:0]);
    assign ea      = base + simm;
    assign br_off  = {{6{w[25]}}, w[25:2], 2'b00};

    always_comb begin
        n_pc     = r_pc;
        n_lr     = r_lr;
        n_cr     = r_cr;
        n_halt   = r_halt;
        n_wait   = r_wait;
        n_ldst   = r_ldst;
        ex_we    = 1'b0;
        rf_waddr = f_rd;
        rf_wdata = 32'd0;
        alu      = 32'd0;
        n_out    = '0;
        if (r_halt) begin
            n_halt = r_halt;
        end else if (r_ex.opcode == ppcisc_pkg::SEL_LOAD) begin
            if (r_wait) begin
                ex_we    = 1'b1;
                rf_waddr = r_ldst;
                rf_wdata = r_ex.load_data;
                n_wait   = 1'b0;
            end
        end else if (!r_wait) begin
            n_pc = r_pc + 32'd4;
            case (primary)
                ppcisc_pkg::OP_ADDI: begin
                    ex_we    = 1'b1;
                    rf_wdata = base + simm;
                end
                ppcisc_pkg::OP_ADDIS: begin
                    ex_we    = 1'b1;
                    rf_wdata = base + {w[15:0], 16'd0};
                end
                ppcisc_pkg::OP_BRANCH: begin
                    if (w[0]) begin
                        n_lr = r_pc + 32'd4;
                    end
                    n_pc = w[1] ? br_off : (r_pc + br_off);
                end
                ppcisc_pkg::OP_LWZ: begin
                    n_out.mem_read    = 1'b1;
                    n_out.mem_address = ea;
                    n_wait            = 1'b1;
                    n_ldst            = f_rd;
                end
                ppcisc_pkg::OP_STW: begin
                    n_out.mem_write   = 1'b1;
                    n_out.mem_address = ea;
                    n_out.store_data  = r_rd_b;
                end
                ppcisc_pkg::OP_ORI: begin
                    ex_we    = 1'b1;
                    rf_waddr = f_ra;
                    rf_wdata = r_rd_b | {16'd0, w[15:0]};
                end
                ppcisc_pkg::OP_ORIS: begin
                    ex_we    = 1'b1;
                    rf_waddr = f_ra;
                    rf_wdata = r_rd_b | {w[15:0], 16'd0};
                end
                ppcisc_pkg::OP_RLWINM: begin
                    alu      = ppcisc_pkg::rotl32(r_rd_b, f_rb)
                             & ppcisc_pkg::wrap_mask(w[10:6], w[5:1]);
                    ex_we    = 1'b1;
                    rf_waddr = f_ra;
                    rf_wdata = alu;
                    if (w[0]) begin
                        n_cr = ppcisc_pkg::cr0_of(alu);
                    end
                end
                ppcisc_pkg::OP_EXT31: begin
                    if (w[10:1] == ppcisc_pkg::XO_ADD || w[10:1] == ppcisc_pkg::XO_SUBF) begin
                        alu      = (w[10:1] == ppcisc_pkg::XO_ADD) ? (r_rd_a + r_rd_b)
                                                                   : (r_rd_b - r_rd_a);
                        ex_we    = 1'b1;
                        rf_wdata = alu;
                        if (w[0]) begin
                            n_cr = ppcisc_pkg::cr0_of(alu);
                        end
                    end else begin
                        n_halt = 1'b1;
                        n_pc   = r_pc;
                    end
                end
                default: begin
                    n_halt = 1'b1;
                    n_pc   = r_pc;
                end
            endcase
        end
        n_out.fetch_address = n_pc;
        n_out.cr0_bits      = n_cr;
        n_out.fault         = n_halt;
    end

    assign rf_we = adv && ex_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_pc <= 32'd0;
            r_pc       <= 32'd0;
            r_lr       <= 32'd0;
            r_cr       <= 4'd0;
            r_halt     <= 1'b0;
            r_wait     <= 1'b0;
            r_ldst     <= 5'd0;
        end else if (cfg_wr) begin
            if (paddr[2] == ppcisc_pkg::REG_RESET_PC) begin
                r_reset_pc <= pwdata;
                r_pc       <= pwdata;
            end
        end else if (adv) begin
            r_pc   <= n_pc;
            r_lr   <= n_lr;
            r_cr   <= n_cr;
            r_halt <= n_halt;
            r_wait <= n_wait;
            r_ldst <= n_ldst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ex_vld <= 1'b1;
            end else if (adv) begin
                r_ex_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ex <= i_in;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hdl/ppcisc_checker.sv
// ----------------------------------------------------------------------------
// ppcisc_checker
// Port-level checks for the PowerPC integer subset core, bound to the top.
// ----------------------------------------------------------------------------
`include "powerpc_integer_subset_core_unit_macros.svh"

module ppcisc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input ppcisc_pkg::t_out_beat o_out
);

    logic r_seen_fault;

    // a delivered fault beat means the core stays halted until reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fault <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out.fault) begin
            r_seen_fault <= 1'b1;
        end
    end

    `PPCISC_ASSERT(a_out_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result beat dropped while stalled")
    `PPCISC_ASSERT_HOLD(a_out_beat_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out, "stalled result beat changed")
    `PPCISC_ASSERT(a_fault_sticky, i_clk, i_rst_n, o_out_valid && r_seen_fault |-> o_out.fault, "fault cleared without reset")
    `PPCISC_ASSERT(a_mem_onehot, i_clk, i_rst_n, o_out_valid |-> !(o_out.mem_read && o_out.mem_write), "load and store in one beat")
    `PPCISC_ASSERT(a_fault_no_mem, i_clk, i_rst_n, o_out_valid && o_out.fault |-> !o_out.mem_read && !o_out.mem_write, "memory access from halted core")

endmodule

bind powerpc_integer_subset_core_unit ppcisc_checker u_ppcisc_checker (.*);

>>> test/ppc_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppc_core_checker
// Watches the instruction/load channel and the config port, runs its own copy
// of the core's architectural state, and compares every result beat in order.
// ----------------------------------------------------------------------------
module ppc_core_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  ppcisc_pkg::t_in_beat  i_in_beat,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  ppcisc_pkg::t_out_beat i_out_beat,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [2:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [31:0] gpr [0:31];
    logic [31:0] pc;
    logic [31:0] lr;
    logic [3:0]  cr;
    logic        halted;
    logic        ld_wait;
    logic [4:0]  ld_dest;
    ppcisc_pkg::t_out_beat step_results_q[$];
    int          n_fail = 0;

    function automatic logic [3:0] cr_field(input logic [31:0] v);
        logic [3:0] c;
        if (v == 32'd0) begin
            c = ppcisc_pkg::CR_ZERO;
        end else if (v[31]) begin
            c = ppcisc_pkg::CR_NEG;
        end else begin
            c = ppcisc_pkg::CR_POS;
        end
        return c;
    endfunction

    // bit numbering as in the ISA: bit 0 is the msb
    function automatic logic [31:0] rlw_mask(input logic [4:0] mb, input logic [4:0] me);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++) begin
            if (mb <= me) begin
                m[31 - b] = (b >= mb) && (b <= me);
            end else begin
                m[31 - b] = (b >= mb) || (b <= me);
            end
        end
        return m;
    endfunction

    task automatic run_core_step(input ppcisc_pkg::t_in_beat b,
                                 output ppcisc_pkg::t_out_beat r);
        logic [31:0] w;
        logic [31:0] cia;
        logic [31:0] nia;
        logic [31:0] simm;
        logic [31:0] base;
        logic [31:0] res;
        logic [31:0] off;
        logic [63:0] dbl;
        logic [4:0]  rt;
        logic [4:0]  ra;
        logic [4:0]  rb;
        w = b.instruction_word;
        r = '0;
        if (halted) begin
            // frozen
        end else if (b.opcode == ppcisc_pkg::SEL_LOAD) begin
            if (ld_wait) begin
                gpr[ld_dest] = b.load_data;
                ld_wait = 1'b0;
            end
        end else if (!ld_wait) begin
            cia  = pc;
            nia  = cia + 32'd4;
            rt   = w[25:21];
            ra   = w[20:16];
            rb   = w[15:11];
            simm = {{16{w[15]}}, w[15:0]};
            base = (ra == 5'd0) ? 32'd0 : gpr[ra];
            case (w[31:26])
                ppcisc_pkg::OP_ADDI: begin
                    gpr[rt] = base + simm;
                end
                ppcisc_pkg::OP_ADDIS: begin
                    gpr[rt] = base + {w[15:0], 16'h0000};
                end
                ppcisc_pkg::OP_BRANCH: begin
                    off = {{6{w[25]}}, w[25:2], 2'b00};
                    if (w[0]) begin
                        lr = nia;
                    end
                    nia = w[1] ? off : cia + off;
                end
                ppcisc_pkg::OP_LWZ: begin
                    r.mem_read    = 1'b1;
                    r.mem_address = base + simm;
                    ld_wait       = 1'b1;
                    ld_dest       = rt;
                end
                ppcisc_pkg::OP_STW: begin
                    r.mem_write   = 1'b1;
                    r.mem_address = base + simm;
                    r.store_data  = gpr[rt];
                end
                ppcisc_pkg::OP_ORI: begin
                    gpr[ra] = gpr[rt] | {16'h0000, w[15:0]};
                end
                ppcisc_pkg::OP_ORIS: begin
                    gpr[ra] = gpr[rt] | {w[15:0], 16'h0000};
                end
                ppcisc_pkg::OP_RLWINM: begin
                    dbl = {gpr[rt], gpr[rt]} << rb;
                    res = dbl[63:32] & rlw_mask(w[10:6], w[5:1]);
                    gpr[ra] = res;
                    if (w[0]) begin
                        cr = cr_field(res);
                    end
                end
                ppcisc_pkg::OP_EXT31: begin
                    if (w[10:1] == ppcisc_pkg::XO_ADD || w[10:1] == ppcisc_pkg::XO_SUBF) begin
                        res = (w[10:1] == ppcisc_pkg::XO_ADD) ? gpr[ra] + gpr[rb]
                                                             : gpr[rb] - gpr[ra];
                        gpr[rt] = res;
                        if (w[0]) begin
                            cr = cr_field(res);
                        end
                    end else begin
                        halted = 1'b1;
                        nia    = cia;
                    end
                end
                default: begin
                    halted = 1'b1;
                    nia    = cia;
                end
            endcase
            pc = nia;
        end
        r.fetch_address = pc;
        r.cr0_bits      = cr;
        r.fault         = halted;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (n_fail < 10) begin
                $display("mismatch on %s: expected %h, got %h", name, want, got);
            end
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        ppcisc_pkg::t_out_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) begin
                gpr[k] = '0;
            end
            pc       = '0;
            lr       = '0;
            cr       = '0;
            halted   = 1'b0;
            ld_wait  = 1'b0;
            ld_dest  = '0;
            step_results_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == {ppcisc_pkg::REG_RESET_PC, 2'b00}) begin
                pc = i_pwdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (step_results_q.size() == 0) begin
                    if (n_fail < 10) begin
                        $display("result beat with nothing expected: fetch_address %h",
                                 i_out_beat.fetch_address);
                    end
                    n_fail++;
                end else begin
                    want = step_results_q.pop_front();
                    check_field("fetch_address", want.fetch_address,
                                i_out_beat.fetch_address);
                    check_field("mem_read", 32'(want.mem_read),
                                32'(i_out_beat.mem_read));
                    check_field("mem_write", 32'(want.mem_write),
                                32'(i_out_beat.mem_write));
                    check_field("mem_address", want.mem_address,
                                i_out_beat.mem_address);
                    check_field("store_data", want.store_data,
                                i_out_beat.store_data);
                    check_field("cr0_bits", 32'(want.cr0_bits),
                                32'(i_out_beat.cr0_bits));
                    check_field("fault", 32'(want.fault),
                                32'(i_out_beat.fault));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                run_core_step(i_in_beat, want);
                step_results_q.push_back(want);
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= step_results_q.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the PowerPC subset core with directed and random instruction streams,
// load returns and reset_pc writes, with random gaps and output stalls; the
// checker beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [3:0] {
        K_ADDI, K_ADDIS, K_BRANCH, K_LWZ, K_STW,
        K_ORI, K_ORIS, K_RLWINM, K_ADD, K_SUBF
    } e_insn_kind;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    ppcisc_pkg::t_in_beat  i_in        = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [2:0]            paddr       = '0;
    logic [31:0]           pwdata      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    ppcisc_pkg::t_out_beat o_out;
    logic [31:0]           prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    int   cycles     = 0;
    int   stall_left = 0;
    logic quiet      = 1'b0;
    logic ld_open    = 1'b0;

    always #6 i_clk = ~i_clk;

    powerpc_integer_subset_core_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    ppc_core_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_beat    (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_beat   (o_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("powerpc_integer_subset_core_unit regression: fail");
            $finish;
        end
    end

    // result-side backpressure: mostly free, short stalls, a few long ones
    always @(posedge i_clk) begin
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (quiet || roll < 70) begin
            i_out_stall <= 1'b0;
        end else if (roll < 95) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(8, 30);
        end
    end

    function automatic logic [31:0] d_form(input logic [5:0] op, input logic [4:0] rt,
                                           input logic [4:0] ra, input logic [15:0] imm);
        return {op, rt, ra, imm};
    endfunction

    function automatic logic [31:0] x_form(input logic [4:0] rt, input logic [4:0] ra,
                                           input logic [4:0] rb, input logic [9:0] xo,
                                           input logic rc);
        return {ppcisc_pkg::OP_EXT31, rt, ra, rb, xo, rc};
    endfunction

    function automatic logic [31:0] m_form(input logic [4:0] rs, input logic [4:0] ra,
                                           input logic [4:0] sh, input logic [4:0] mb,
                                           input logic [4:0] me, input logic rc);
        return {ppcisc_pkg::OP_RLWINM, rs, ra, sh, mb, me, rc};
    endfunction

    function automatic logic [31:0] b_form(input logic [23:0] li, input logic aa,
                                           input logic lk);
        return {ppcisc_pkg::OP_BRANCH, li, aa, lk};
    endfunction

    function automatic logic [15:0] rand_imm();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h7FFF;
            3:       v = 16'h8000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_insn();
        e_insn_kind  k;
        logic [4:0]  rt;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic        rc;
        logic [31:0] w;
        k  = e_insn_kind'($urandom_range(0, 9));
        rt = 5'($urandom);
        ra = 5'($urandom);
        rb = 5'($urandom);
        rc = 1'($urandom);
        case (k)
            K_ADDI:   w = d_form(ppcisc_pkg::OP_ADDI, rt, ra, rand_imm());
            K_ADDIS:  w = d_form(ppcisc_pkg::OP_ADDIS, rt, ra, rand_imm());
            K_BRANCH: w = b_form(24'($urandom), 1'($urandom), 1'($urandom));
            K_LWZ:    w = d_form(ppcisc_pkg::OP_LWZ, rt, ra, rand_imm());
            K_STW:    w = d_form(ppcisc_pkg::OP_STW, rt, ra, rand_imm());
            K_ORI:    w = d_form(ppcisc_pkg::OP_ORI, rt, ra, rand_imm());
            K_ORIS:   w = d_form(ppcisc_pkg::OP_ORIS, rt, ra, rand_imm());
            K_RLWINM: w = m_form(rt, ra, rb, 5'($urandom), 5'($urandom), rc);
            K_ADD:    w = x_form(rt, ra, rb, ppcisc_pkg::XO_ADD, rc);
            default:  w = x_form(rt, ra, rb, ppcisc_pkg::XO_SUBF, rc);
        endcase
        return w;
    endfunction

    function automatic int pick_gap();
        int unsigned roll;
        int          gap;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 70) begin
            gap = 0;
        end else if (roll < 95) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        return gap;
    endfunction

    task automatic send_beat(input ppcisc_pkg::t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_insn(input logic [31:0] w);
        ppcisc_pkg::t_in_beat b;
        b.opcode           = ppcisc_pkg::SEL_INSN;
        b.instruction_word = w;
        b.load_data        = $urandom;
        if (!ld_open && w[31:26] == ppcisc_pkg::OP_LWZ) begin
            ld_open = 1'b1;
        end
        send_beat(b);
    endtask

    task automatic send_load(input logic [31:0] d);
        ppcisc_pkg::t_in_beat b;
        b.opcode           = ppcisc_pkg::SEL_LOAD;
        b.instruction_word = $urandom;
        b.load_data        = d;
        ld_open            = 1'b0;
        send_beat(b);
    endtask

    // hold off until every expected beat is back, then let the pipe empty
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ppcisc_pkg::REG_RESET_PC, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int n);
        int          done;
        int unsigned roll;
        done = 0;
        while (done < n) begin
            if (done % 100 == 0) begin
                quiet <= ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (ld_open) begin
                if (roll < 88) begin
                    send_load($urandom);
                    done++;
                end else begin
                    send_insn(rand_insn());
                end
            end else if (roll < 3) begin
                send_load($urandom);
            end else begin
                send_insn(rand_insn());
                done++;
            end
        end
        if (ld_open) begin
            send_load($urandom);
        end
        quiet <= 1'b0;
    endtask

    initial begin
        logic [5:0]  bad_op;
        logic [9:0]  bad_xo;
        logic [31:0] bad_word;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(32'hFFFF_FFFC);
        send_insn(d_form(ppcisc_pkg::OP_ADDI, 5'd1, 5'd0, 16'h7FFF));
        send_insn(d_form(ppcisc_pkg::OP_ADDI, 5'd2, 5'd0, 16'h8000));
        send_insn(d_form(ppcisc_pkg::OP_ADDIS, 5'd3, 5'd0, 16'hFFFF));
        send_insn(d_form(ppcisc_pkg::OP_ORI, 5'd3, 5'd3, 16'hFFFF));
        send_insn(d_form(ppcisc_pkg::OP_ORIS, 5'd0, 5'd4, 16'h8000));
        send_insn(x_form(5'd5, 5'd3, 5'd3, ppcisc_pkg::XO_ADD, 1'b1));
        send_insn(x_form(5'd6, 5'd3, 5'd3, ppcisc_pkg::XO_SUBF, 1'b1));
        send_insn(x_form(5'd7, 5'd1, 5'd6, ppcisc_pkg::XO_ADD, 1'b1));
        send_insn(m_form(5'd4, 5'd8, 5'd1, 5'd30, 5'd1, 1'b1));
        send_insn(m_form(5'd3, 5'd9, 5'd0, 5'd0, 5'd31, 1'b0));
        send_insn(m_form(5'd3, 5'd10, 5'd31, 5'd31, 5'd0, 1'b1));
        // r0 as a target, then as a zero base, then as a plain operand
        send_insn(d_form(ppcisc_pkg::OP_ADDI, 5'd0, 5'd0, 16'd5));
        send_insn(d_form(ppcisc_pkg::OP_ADDI, 5'd11, 5'd0, 16'd1));
        send_insn(x_form(5'd12, 5'd0, 5'd0, ppcisc_pkg::XO_ADD, 1'b0));
        send_insn(d_form(ppcisc_pkg::OP_STW, 5'd0, 5'd0, 16'hFFFC));
        send_insn(d_form(ppcisc_pkg::OP_STW, 5'd3, 5'd1, 16'h7FFF));
        send_insn(d_form(ppcisc_pkg::OP_LWZ, 5'd13, 5'd1, 16'h8000));
        send_load(32'hFFFF_FFFF);
        send_insn(d_form(ppcisc_pkg::OP_LWZ, 5'd0, 5'd0, 16'h0000));
        // dropped, load pending
        send_insn(d_form(ppcisc_pkg::OP_ADDI, 5'd14, 5'd0, 16'h1234));
        send_load(32'h0000_0000);
        send_load(32'h8000_0001);                             // dropped, no load pending
        send_insn(b_form(24'hFF_FFFF, 1'b0, 1'b1));
        send_insn(b_form(24'h7F_FFFF, 1'b1, 1'b0));
        send_insn(b_form(24'h80_0000, 1'b0, 1'b0));
        drain();

        cfg_write(32'h0000_0000);
        run_random(150);
        drain();
        run_random(150);
        drain();
        cfg_write($urandom);
        run_random(300);
        drain();
        cfg_write(32'hFFFF_FFFF);
        run_random(300);
        drain();

        // halt is permanent, so the unsupported-instruction case comes last
        if ($urandom_range(0, 1) == 1) begin
            bad_op = 6'($urandom);
            while (bad_op == ppcisc_pkg::OP_ADDI || bad_op == ppcisc_pkg::OP_ADDIS ||
                   bad_op == ppcisc_pkg::OP_BRANCH || bad_op == ppcisc_pkg::OP_RLWINM ||
                   bad_op == ppcisc_pkg::OP_ORI || bad_op == ppcisc_pkg::OP_ORIS ||
                   bad_op == ppcisc_pkg::OP_EXT31 || bad_op == ppcisc_pkg::OP_LWZ ||
                   bad_op == ppcisc_pkg::OP_STW) begin
                bad_op = 6'($urandom);
            end
            bad_word = {bad_op, 26'($urandom)};
        end else begin
            bad_xo = 10'($urandom);
            while (bad_xo == ppcisc_pkg::XO_ADD || bad_xo == ppcisc_pkg::XO_SUBF) begin
                bad_xo = 10'($urandom);
            end
            bad_word = x_form(5'($urandom), 5'($urandom), 5'($urandom), bad_xo,
                              1'($urandom));
        end
        send_insn(bad_word);
        send_insn(rand_insn());
        send_insn(d_form(ppcisc_pkg::OP_LWZ, 5'd2, 5'd1, rand_imm()));
        send_load($urandom);
        send_insn(d_form(ppcisc_pkg::OP_STW, 5'd3, 5'd0, rand_imm()));
        drain();

        if (fail_count == 0) begin
            $display("powerpc_integer_subset_core_unit regression: pass");
        end else begin
            $display("powerpc_integer_subset_core_unit regression: fail");
        end
        $finish;
    end

endmodule
